FILE: rtl/rtspdf_pkg.sv
package rtspdf_pkg;

   // character codes
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_CR     = 8'h0d;
   localparam logic [7:0] CHAR_LF     = 8'h0a;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   // length of the "Content-Length:" keyword
   localparam logic [3:0] KEY_LEN = 4'd15;

   // result kinds
   localparam logic [1:0] KIND_BIN  = 2'd0;
   localparam logic [1:0] KIND_TEXT = 2'd1;
   localparam logic [1:0] KIND_BODY = 2'd2;

   // top level message mode
   typedef enum logic [4:0] {
      MODE_IDLE   = 5'b00001,
      MODE_BINHDR = 5'b00010,
      MODE_BINPAY = 5'b00100,
      MODE_TEXT   = 5'b01000,
      MODE_BODY   = 5'b10000
   } mode_type;

   // content length number parser phase
   typedef enum logic [3:0] {
      NUM_OFF    = 4'b0001,
      NUM_SKIP   = 4'b0010,
      NUM_DIGITS = 4'b0100,
      NUM_DONE   = 4'b1000
   } num_phase_type;

   // header scanner report for the current byte
   typedef struct packed {
      logic        done;
      logic        to_body;
      logic [15:0] body_length;
   } scan_result_type;

   // keyword character at a given match position
   function automatic logic [7:0] key_char(input logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = 8'h43; // C
         4'd1:    c = 8'h6f; // o
         4'd2:    c = 8'h6e; // n
         4'd3:    c = 8'h74; // t
         4'd4:    c = 8'h65; // e
         4'd5:    c = 8'h6e; // n
         4'd6:    c = 8'h74; // t
         4'd7:    c = 8'h2d; // -
         4'd8:    c = 8'h4c; // L
         4'd9:    c = 8'h65; // e
         4'd10:   c = 8'h6e; // n
         4'd11:   c = 8'h67; // g
         4'd12:   c = 8'h74; // t
         4'd13:   c = 8'h68; // h
         4'd14:   c = 8'h3a; // :
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/rtspdf_text_scan.sv
module rtspdf_text_scan (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  logic                       fresh,
   input  logic [7:0]                 byte_in,
   output rtspdf_pkg::scan_result_type result
);

   logic [3:0]                 key_ff, key_in, key_cur, key_next;
   rtspdf_pkg::num_phase_type  phase_ff, phase_in, phase_cur;
   logic [15:0]                len_ff, len_in, len_cur, len_x10;
   logic [1:0]                 term_ff, term_in, term_cur;
   logic                       is_digit, is_blank, done;

   // a new header starts from a cleared scan state
   always_comb begin
      key_cur   = fresh ? 4'd0 : key_ff;
      phase_cur = fresh ? rtspdf_pkg::NUM_OFF : phase_ff;
      len_cur   = fresh ? 16'd0 : len_ff;
      term_cur  = fresh ? 2'd0 : term_ff;
   end

   assign is_digit = (byte_in >= rtspdf_pkg::CHAR_ZERO) && (byte_in <= rtspdf_pkg::CHAR_NINE);
   assign is_blank = (byte_in == rtspdf_pkg::CHAR_SPACE) || (byte_in == rtspdf_pkg::CHAR_TAB);
   assign len_x10  = {len_cur[12:0], 3'b000} + {len_cur[14:0], 1'b0};

   // keyword match and decimal length parse
   always_comb begin
      key_in   = key_cur;
      phase_in = phase_cur;
      len_in   = len_cur;
      key_next = 4'd0;
      unique case (phase_cur) inside
         rtspdf_pkg::NUM_OFF: begin
            if (key_cur != rtspdf_pkg::KEY_LEN && byte_in == rtspdf_pkg::key_char(key_cur))
               key_next = key_cur + 4'd1;
            else
               key_next = (byte_in == rtspdf_pkg::key_char(4'd0)) ? 4'd1 : 4'd0;
            if (key_next == rtspdf_pkg::KEY_LEN) begin
               key_in   = 4'd0;
               phase_in = rtspdf_pkg::NUM_SKIP;
               len_in   = 16'd0;
            end else begin
               key_in = key_next;
            end
         end
         rtspdf_pkg::NUM_SKIP, rtspdf_pkg::NUM_DIGITS: begin
            if (is_digit) begin
               len_in   = len_x10 + {12'd0, byte_in[3:0]};
               phase_in = rtspdf_pkg::NUM_DIGITS;
            end else if (!(phase_cur == rtspdf_pkg::NUM_SKIP && is_blank)) begin
               phase_in = rtspdf_pkg::NUM_DONE;
            end
         end
         default: begin
         end
      endcase

      // crlf crlf terminator tracking
      done = 1'b0;
      if ((term_cur == 2'd0 || term_cur == 2'd2) && byte_in == rtspdf_pkg::CHAR_CR)
         term_in = term_cur + 2'd1;
      else if (term_cur == 2'd1 && byte_in == rtspdf_pkg::CHAR_LF)
         term_in = 2'd2;
      else if (term_cur == 2'd3 && byte_in == rtspdf_pkg::CHAR_LF) begin
         term_in = 2'd0;
         done    = 1'b1;
      end else
         term_in = (byte_in == rtspdf_pkg::CHAR_CR) ? 2'd1 : 2'd0;

      result.done        = done;
      result.to_body     = done && (phase_in != rtspdf_pkg::NUM_OFF) && (len_in != 16'd0);
      result.body_length = len_in;

      // end of header clears the scan state
      if (done) begin
         key_in   = 4'd0;
         phase_in = rtspdf_pkg::NUM_OFF;
         len_in   = 16'd0;
      end
   end

   // scan state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= 4'd0;
         phase_ff <= rtspdf_pkg::NUM_OFF;
         len_ff   <= 16'd0;
         term_ff  <= 2'd0;
      end else if (enable) begin
         key_ff   <= key_in;
         phase_ff <= phase_in;
         len_ff   <= len_in;
         term_ff  <= term_in;
      end
   end

endmodule

FILE: rtl/rtsp_interleaved_deframer.sv
// channel    direction  ports
// req        in         req_valid, req_stall, req_byte_in
// rsp        out        rsp_valid, rsp_stall, rsp_byte_out, rsp_channel, rsp_kind,
//                       rsp_last, rsp_empty_res
//
// one byte per clock while req_stall is low; each byte is decoded in the cycle it is
// accepted and its item, if any, sits in the output register the next cycle
// synchronous active high reset returns the deframer to idle
// req_stall rises only while the output register holds an item and rsp_stall is high
module rtsp_interleaved_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_byte_out,
   output logic [7:0] rsp_channel,
   output logic [1:0] rsp_kind,
   output logic       rsp_last,
   output logic       rsp_empty_res
);

   rtspdf_pkg::mode_type        mode_ff, mode_in;
   logic [1:0]                  hdr_count_ff, hdr_count_in;
   logic [7:0]                  channel_ff, channel_in;
   logic [7:0]                  len_high_ff, len_high_in;
   logic [15:0]                 left_ff, left_in, left_dec, frame_len;
   rtspdf_pkg::scan_result_type scan;
   logic                        accept, scan_en, scan_fresh;
   logic                        res_valid, res_last, res_empty;
   logic [7:0]                  res_byte, res_channel;
   logic [1:0]                  res_kind;
   logic                        valid_ff, valid_in;
   logic [7:0]                  byte_ff, chan_out_ff;
   logic [1:0]                  kind_ff;
   logic                        last_ff, empty_ff;

   assign req_stall = valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // header text goes through the scanner; idle bytes other than dollar open a header
   assign scan_fresh = (mode_ff != rtspdf_pkg::MODE_TEXT);
   assign scan_en    = accept && (mode_ff != rtspdf_pkg::MODE_BINHDR) &&
                       (mode_ff != rtspdf_pkg::MODE_BINPAY) &&
                       (mode_ff != rtspdf_pkg::MODE_BODY) &&
                       !(scan_fresh && req_byte_in == rtspdf_pkg::CHAR_DOLLAR);

   rtspdf_text_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .enable  (scan_en),
      .fresh   (scan_fresh),
      .byte_in (req_byte_in),
      .result  (scan)
   );

   assign left_dec  = left_ff - 16'd1;
   assign frame_len = {len_high_ff, req_byte_in};

   // message decode for the accepted byte
   always_comb begin
      mode_in      = mode_ff;
      hdr_count_in = hdr_count_ff;
      channel_in   = channel_ff;
      len_high_in  = len_high_ff;
      left_in      = left_ff;
      res_valid    = 1'b0;
      res_byte     = req_byte_in;
      res_channel  = 8'd0;
      res_kind     = rtspdf_pkg::KIND_TEXT;
      res_last     = 1'b0;
      res_empty    = 1'b0;
      unique case (mode_ff) inside
         rtspdf_pkg::MODE_BINHDR: begin
            if (hdr_count_ff == 2'd0) begin
               channel_in   = req_byte_in;
               hdr_count_in = 2'd1;
            end else if (hdr_count_ff == 2'd1) begin
               len_high_in  = req_byte_in;
               hdr_count_in = 2'd2;
            end else begin
               hdr_count_in = 2'd0;
               left_in      = frame_len;
               if (frame_len == 16'd0) begin
                  mode_in     = rtspdf_pkg::MODE_IDLE;
                  res_valid   = 1'b1;
                  res_byte    = 8'd0;
                  res_channel = channel_ff;
                  res_kind    = rtspdf_pkg::KIND_BIN;
                  res_last    = 1'b1;
                  res_empty   = 1'b1;
               end else begin
                  mode_in = rtspdf_pkg::MODE_BINPAY;
               end
            end
         end
         rtspdf_pkg::MODE_BINPAY, rtspdf_pkg::MODE_BODY: begin
            left_in   = left_dec;
            res_valid = 1'b1;
            res_last  = (left_dec == 16'd0);
            if (mode_ff == rtspdf_pkg::MODE_BINPAY) begin
               res_channel = channel_ff;
               res_kind    = rtspdf_pkg::KIND_BIN;
            end else begin
               res_kind = rtspdf_pkg::KIND_BODY;
            end
            if (left_dec == 16'd0)
               mode_in = rtspdf_pkg::MODE_IDLE;
         end
         default: begin
            // idle, header text, and any stray code handled as idle
            if (scan_fresh && req_byte_in == rtspdf_pkg::CHAR_DOLLAR) begin
               mode_in      = rtspdf_pkg::MODE_BINHDR;
               hdr_count_in = 2'd0;
            end else begin
               res_valid = 1'b1;
               res_last  = scan.done;
               if (scan.done && scan.to_body) begin
                  left_in = scan.body_length;
                  mode_in = rtspdf_pkg::MODE_BODY;
               end else if (scan.done) begin
                  mode_in = rtspdf_pkg::MODE_IDLE;
               end else begin
                  mode_in = rtspdf_pkg::MODE_TEXT;
               end
            end
         end
      endcase
   end

   // deframer state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= rtspdf_pkg::MODE_IDLE;
         hdr_count_ff <= 2'd0;
         channel_ff   <= 8'd0;
         len_high_ff  <= 8'd0;
         left_ff      <= 16'd0;
      end else if (accept) begin
         mode_ff      <= mode_in;
         hdr_count_ff <= hdr_count_in;
         channel_ff   <= channel_in;
         len_high_ff  <= len_high_in;
         left_ff      <= left_in;
      end
   end

   // output register
   always_comb begin
      if (accept)
         valid_in = res_valid;
      else if (!rsp_stall)
         valid_in = 1'b0;
      else
         valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff     <= res_byte;
         chan_out_ff <= res_channel;
         kind_ff     <= res_kind;
         last_ff     <= res_last;
         empty_ff    <= res_empty;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_byte_out  = byte_ff;
   assign rsp_channel   = chan_out_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_last      = last_ff;
   assign rsp_empty_res = empty_ff;

`ifndef SYNTHESIS
   // an empty frame item is a final binary item with a zero byte
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && empty_ff) |->
         (last_ff && byte_ff == 8'd0 && kind_ff == rtspdf_pkg::KIND_BIN))
      else $error("empty item malformed");

   // text and body items carry channel zero
   a_text_channel: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff != rtspdf_pkg::KIND_BIN) |-> (chan_out_ff == 8'd0))
      else $error("nonzero channel on text item");

   // channel and high length bytes give no item
   a_hdr_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && mode_ff == rtspdf_pkg::MODE_BINHDR && hdr_count_ff != 2'd2) |=> !valid_ff)
      else $error("item from frame header byte");

   // payload and body modes always have bytes outstanding
   a_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == rtspdf_pkg::MODE_BODY || mode_ff == rtspdf_pkg::MODE_BINPAY) |->
         (left_ff != 16'd0))
      else $error("payload mode with zero bytes left");
`endif

endmodule
